>>> rtl/scne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scne_pkg;

  localparam int unsigned CHAN_W     = 2;
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned LEVEL_W    = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned EMA_W      = 20;
  localparam int unsigned QUO_W      = LEVEL_W;
  localparam int unsigned QCNT_W     = $clog2(QUO_W + 1);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 17'h10000;
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = 17'h08000;
  localparam logic [EMA_W-1:0]   EMA_BIAS   = 20'd5;
  localparam logic [EMA_W-1:0]   EMA_RECIP  = 20'hCCCCD;
  localparam int unsigned        EMA_SHIFT  = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FILTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAL    = 2'd1;

  typedef enum logic [1:0] {
    ACT_SAMPLE       = 2'd0,
    ACT_TRACK_START  = 2'd1,
    ACT_TRACK_SAMPLE = 2'd2,
    ACT_COMMIT       = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_FILT,
    ST_EMA,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t           action;
    logic [CHAN_W-1:0] channel;
    logic [RAW_W-1:0]  raw_sample;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  out_channel;
    logic [RAW_W-1:0]   out_raw;
    logic [LEVEL_W-1:0] level;
  } out_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

>>> rtl/scne_div.sv
`timescale 1ns / 1ps
`default_nettype none
module scne_div
  import scne_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [SAMPLE_BITS+FRAC_W-1:0] num,
  input  wire logic [SAMPLE_BITS-1:0]      den,
  output div_stat_t                        stat,
  output logic      [QUO_W-1:0]            quot
);

  localparam int unsigned SW    = SAMPLE_BITS;
  localparam int unsigned NUM_W = SW + FRAC_W;

  logic [SW-1:0]     rem_r, rem_nxt;
  logic [SW-1:0]     den_r, den_nxt;
  logic [QUO_W-1:0]  low_r, low_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SW:0]       trial;
  logic              ge;

  always_comb begin
    trial    = {rem_r, low_r[QUO_W-1]};
    ge       = (trial >= {1'b0, den_r});
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, num[NUM_W-1:QUO_W]};
      low_nxt  = num[QUO_W-1:0];
      den_nxt  = den;
      cnt_nxt  = QCNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? SW'(trial - {1'b0, den_r}) : trial[SW-1:0];
      low_nxt = {low_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - QCNT_W'(1);
      if (cnt_r == QCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    low_r <= low_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = low_r;

endmodule
`default_nettype wire

>>> rtl/sensor_calibrate_normalize_ema_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                   Handshake
// request   in_valid, in_ready, in_data             valid/ready
// result    out_valid, out_ready, out_data          valid/ready
// config    cfg_we, cfg_index, cfg_data             write on cfg_we
//
// A sample needing division runs the 17 steps of the shared radix-2 divider, then the
// filter state and, with filtering on, the EMA state. Samples at a clamped level, or at
// half scale for an empty range, skip the division. Calibration requests leave the core
// idle and ready. Reset is synchronous and sets the control state and tables, not the datapath.
// A finished result waits in the output register; the next request is taken once it loads.
module sensor_calibrate_normalize_ema_core
  import scne_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = 4,
  parameter int unsigned SAMPLE_BITS   = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_req_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_res_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SW       = SAMPLE_BITS;
  localparam int unsigned NUM_W    = SW + FRAC_W;
  localparam int unsigned CH_W     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned FS_INT   = (1 << SAMPLE_BITS) - 1;
  localparam logic [SW-1:0] FULL_SCALE = SW'(FS_INT);

  state_t state_r, state_nxt;

  logic               filt_en_r, filt_en_nxt;
  logic               cal_en_r, cal_en_nxt;
  logic               cal_done_r, cal_done_nxt;
  logic [LEVEL_W-1:0] smooth_r   [CHANNEL_COUNT];
  logic [LEVEL_W-1:0] smooth_nxt [CHANNEL_COUNT];
  logic [SW-1:0]      range_lo_r [CHANNEL_COUNT];
  logic [SW-1:0]      range_lo_nxt [CHANNEL_COUNT];
  logic [SW-1:0]      range_hi_r [CHANNEL_COUNT];
  logic [SW-1:0]      range_hi_nxt [CHANNEL_COUNT];
  logic [SW-1:0]      trk_lo_r   [CHANNEL_COUNT];
  logic [SW-1:0]      trk_lo_nxt [CHANNEL_COUNT];
  logic [SW-1:0]      trk_hi_r   [CHANNEL_COUNT];
  logic [SW-1:0]      trk_hi_nxt [CHANNEL_COUNT];

  logic [CHAN_W-1:0]  chan_r, chan_nxt;
  logic [CH_W-1:0]    idx_r, idx_nxt;
  logic [RAW_W-1:0]   raw_r, raw_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [EMA_W-1:0]   ema_r, ema_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_res_t           out_data_r, out_data_nxt;

  logic               in_fire;
  logic [CH_W-1:0]    ch_in;
  logic               chan_ok;
  logic [SW-1:0]      raw_c;
  logic [SW-1:0]      rd_lo, rd_hi, span, diff;
  logic               use_cal;
  logic               need_div;
  logic [LEVEL_W-1:0] fix_lvl;
  logic [NUM_W-1:0]   norm_num;
  logic [SW-1:0]      norm_den;
  logic               go_sample;
  logic [EMA_W-1:0]   ema_sum;
  logic [2*EMA_W-1:0] ema_prod;
  logic [LEVEL_W-1:0] ema_lvl;
  logic               out_load;

  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [SW-1:0]      div_den;
  div_stat_t          div_stat;
  logic [QUO_W-1:0]   div_quot;

  scne_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .stat (div_stat),
    .quot (div_quot)
  );

  assign in_fire   = in_valid && in_ready;
  assign ch_in     = CH_W'(in_data.channel);
  assign chan_ok   = (32'(in_data.channel) < CHANNEL_COUNT);
  assign raw_c     = (32'(in_data.raw_sample) > FS_INT) ? FULL_SCALE : SW'(in_data.raw_sample);
  assign rd_lo     = range_lo_r[ch_in];
  assign rd_hi     = range_hi_r[ch_in];
  assign use_cal   = cal_en_r && cal_done_r;
  assign go_sample = in_fire && (in_data.action == ACT_SAMPLE) && chan_ok;
  assign ema_sum   = (EMA_W'(level_r) << 1) + EMA_W'(level_r)
                   + (EMA_W'(smooth_r[idx_r]) << 3) - EMA_W'(smooth_r[idx_r]) + EMA_BIAS;
  assign ema_prod  = {{EMA_W{1'b0}}, ema_r} * {{EMA_W{1'b0}}, EMA_RECIP};
  assign ema_lvl   = ema_prod[EMA_SHIFT +: LEVEL_W];

  always_comb begin
    span     = rd_hi - rd_lo;
    diff     = raw_c - rd_lo;
    need_div = 1'b0;
    fix_lvl  = '0;
    norm_num = '0;
    norm_den = FULL_SCALE;
    priority if (!use_cal) begin
      need_div = 1'b1;
      norm_num = {raw_c, {FRAC_W{1'b0}}} + NUM_W'(FULL_SCALE >> 1);
    end else if (rd_hi <= rd_lo) begin
      fix_lvl = LEVEL_HALF;
    end else if (raw_c <= rd_lo) begin
      fix_lvl = '0;
    end else if (raw_c >= rd_hi) begin
      fix_lvl = LEVEL_ONE;
    end else begin
      need_div = 1'b1;
      norm_num = {diff, {FRAC_W{1'b0}}} + NUM_W'(span >> 1);
      norm_den = span;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (go_sample) state_nxt = need_div ? ST_NORM : ST_FILT;
      ST_NORM: if (div_stat.done) state_nxt = ST_FILT;
      ST_FILT: state_nxt = filt_en_r ? ST_EMA : ST_DONE;
      ST_EMA:  state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_num   = norm_num;
    div_den   = norm_den;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = go_sample && need_div;
      end
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // datapath and state tables
  always_comb begin
    filt_en_nxt   = filt_en_r;
    cal_en_nxt    = cal_en_r;
    cal_done_nxt  = cal_done_r;
    smooth_nxt    = smooth_r;
    range_lo_nxt  = range_lo_r;
    range_hi_nxt  = range_hi_r;
    trk_lo_nxt    = trk_lo_r;
    trk_hi_nxt    = trk_hi_r;
    chan_nxt      = chan_r;
    idx_nxt       = idx_r;
    raw_nxt       = raw_r;
    level_nxt     = level_r;
    ema_nxt       = ema_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_FILTER: begin
          filt_en_nxt = cfg_data[0];
          if (!cfg_data[0]) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) smooth_nxt[c] = '0;
          end
        end
        CFG_IDX_CAL: cal_en_nxt = cfg_data[0];
        default: ;
      endcase
    end

    if (in_fire) begin
      unique case (in_data.action)
        ACT_TRACK_START: begin
          for (int c = 0; c < CHANNEL_COUNT; c++) begin
            trk_lo_nxt[c] = FULL_SCALE;
            trk_hi_nxt[c] = '0;
          end
        end
        ACT_COMMIT: begin
          range_lo_nxt = trk_lo_r;
          range_hi_nxt = trk_hi_r;
          cal_done_nxt = 1'b1;
        end
        ACT_TRACK_SAMPLE: begin
          if (chan_ok) begin
            if (raw_c < trk_lo_r[ch_in]) trk_lo_nxt[ch_in] = raw_c;
            if (raw_c > trk_hi_r[ch_in]) trk_hi_nxt[ch_in] = raw_c;
          end
        end
        ACT_SAMPLE: begin
          if (chan_ok) begin
            chan_nxt  = in_data.channel;
            idx_nxt   = ch_in;
            raw_nxt   = in_data.raw_sample;
            level_nxt = fix_lvl;
          end
        end
        default: ;
      endcase
    end

    if ((state_r == ST_NORM) && div_stat.done) level_nxt = div_quot;
    if (state_r == ST_FILT) ema_nxt = ema_sum;
    if (state_r == ST_EMA) begin
      level_nxt         = ema_lvl;
      smooth_nxt[idx_r] = ema_lvl;
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_channel = chan_r;
      out_data_nxt.out_raw     = raw_r;
      out_data_nxt.level       = level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filt_en_r   <= 1'b1;
      cal_en_r    <= 1'b1;
      cal_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        smooth_r[c]   <= '0;
        range_lo_r[c] <= '0;
        range_hi_r[c] <= FULL_SCALE;
        trk_lo_r[c]   <= FULL_SCALE;
        trk_hi_r[c]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      filt_en_r   <= filt_en_nxt;
      cal_en_r    <= cal_en_nxt;
      cal_done_r  <= cal_done_nxt;
      out_valid_r <= out_valid_nxt;
      smooth_r    <= smooth_nxt;
      range_lo_r  <= range_lo_nxt;
      range_hi_r  <= range_hi_nxt;
      trk_lo_r    <= trk_lo_nxt;
      trk_hi_r    <= trk_hi_nxt;
    end
    chan_r     <= chan_nxt;
    idx_r      <= idx_nxt;
    raw_r      <= raw_nxt;
    level_r    <= level_nxt;
    ema_r      <= ema_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> rtl/scne_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module scne_checker
  import scne_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire in_req_t               in_data,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire out_res_t              out_data
);

  logic in_fire;
  logic sample_fire;

  assign in_fire     = in_valid && in_ready;
  assign sample_fire = in_fire && (in_data.action == ACT_SAMPLE)
                     && (32'(in_data.channel) < CHANNEL_COUNT);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    sample_fire |=> !in_ready)
    else $error("request taken while a sample is in progress");

  a_ready_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !sample_fire |=> in_ready)
    else $error("calibration request did not finish in one cycle");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !$rose(out_valid))
    else $error("result appeared right after a request");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.level <= LEVEL_ONE)
    else $error("level above one");

endmodule

bind sensor_calibrate_normalize_ema_core scne_checker #(
  .CHANNEL_COUNT(CHANNEL_COUNT)
) u_scne_checker (.*);
`default_nettype wire

>>> tb/tb_sensor_calibrate_normalize_ema_core.sv
`timescale 1ns / 1ps
module tb_sensor_calibrate_normalize_ema_core;
  import scne_pkg::*;

  localparam int unsigned CHANNELS      = 4;
  localparam longint unsigned FULL_SCALE = (64'd1 << RAW_W) - 64'd1;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RSVD2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RSVD3 = 2'd3;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    in_req_t                  req;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    logic                     typed;
    logic [LEVEL_W-1:0]       level;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_res_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sensor_calibrate_normalize_ema_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic                 flt_on;
  logic                 cal_on;
  logic                 cal_valid;
  logic [LEVEL_W-1:0]   ema_state [CHANNELS];
  logic [RAW_W-1:0]     cal_low   [CHANNELS];
  logic [RAW_W-1:0]     cal_high  [CHANNELS];
  logic [RAW_W-1:0]     seen_low  [CHANNELS];
  logic [RAW_W-1:0]     seen_high [CHANNELS];

  out_res_t    pending_results [$];
  row_t        plan [$];
  int unsigned fail_count = 0;
  int unsigned requests_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req_cnt;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void model_reset();
    flt_on    = 1'b1;
    cal_on    = 1'b1;
    cal_valid = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      ema_state[c] = '0;
      cal_low[c]   = '0;
      cal_high[c]  = RAW_W'(FULL_SCALE);
      seen_low[c]  = RAW_W'(FULL_SCALE);
      seen_high[c] = '0;
    end
  endfunction

  function automatic logic [LEVEL_W-1:0] scale_raw(input logic [RAW_W-1:0] raw,
                                                   input int unsigned ch);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned span;
    lo = cal_low[ch];
    hi = cal_high[ch];
    if (!cal_on || !cal_valid)
      return LEVEL_W'((64'(raw) * 64'(LEVEL_ONE) + FULL_SCALE / 2) / FULL_SCALE);
    if (hi <= lo) return LEVEL_HALF;
    if (64'(raw) <= lo) return '0;
    if (64'(raw) >= hi) return LEVEL_ONE;
    span = hi - lo;
    return LEVEL_W'(((64'(raw) - lo) * 64'(LEVEL_ONE) + span / 2) / span);
  endfunction

  function automatic bit apply_request(input in_req_t r, output out_res_t res);
    logic [LEVEL_W-1:0] lvl;
    int unsigned        ch;
    ch  = r.channel;
    res = '0;
    case (r.action)
      ACT_TRACK_START: begin
        for (int c = 0; c < CHANNELS; c++) begin
          seen_low[c]  = RAW_W'(FULL_SCALE);
          seen_high[c] = '0;
        end
        return 1'b0;
      end
      ACT_COMMIT: begin
        for (int c = 0; c < CHANNELS; c++) begin
          cal_low[c]  = seen_low[c];
          cal_high[c] = seen_high[c];
        end
        cal_valid = 1'b1;
        return 1'b0;
      end
      ACT_TRACK_SAMPLE: begin
        if (r.raw_sample < seen_low[ch]) seen_low[ch] = r.raw_sample;
        if (r.raw_sample > seen_high[ch]) seen_high[ch] = r.raw_sample;
        return 1'b0;
      end
      default: ;
    endcase
    lvl = scale_raw(r.raw_sample, ch);
    if (flt_on) begin
      lvl = LEVEL_W'((64'd3 * 64'(lvl) + 64'd7 * 64'(ema_state[ch]) + 64'd5) / 64'd10);
      ema_state[ch] = lvl;
    end
    res.out_channel = r.channel;
    res.out_raw     = r.raw_sample;
    res.level       = lvl;
    return 1'b1;
  endfunction

  function automatic in_req_t make_req(input action_t a, input int unsigned ch,
                                       input int unsigned raw);
    in_req_t r;
    r.action     = a;
    r.channel    = CHAN_W'(ch);
    r.raw_sample = RAW_W'(raw);
    return r;
  endfunction

  function automatic int unsigned pick_raw();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return int'(FULL_SCALE);
      default: return $urandom_range(0, int'(FULL_SCALE));
    endcase
  endfunction

  function automatic row_t req_row(input action_t a, input int unsigned ch,
                                   input int unsigned raw);
    row_t row;
    row      = '0;
    row.kind = ROW_REQ;
    row.req  = make_req(a, ch, raw);
    return row;
  endfunction

  function automatic row_t chk_row(input int unsigned ch, input int unsigned raw,
                                   input logic [LEVEL_W-1:0] lvl);
    row_t row;
    row       = req_row(ACT_SAMPLE, ch, raw);
    row.typed = 1'b1;
    row.level = lvl;
    return row;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  task automatic offer_request(input in_req_t r, input bit typed,
                               input logic [LEVEL_W-1:0] typed_level);
    out_res_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (apply_request(r, res)) begin
      if (typed) res.level = typed_level;
      pending_results.push_back(res);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_FILTER) begin
      flt_on = val[0];
      if (!flt_on)
        for (int c = 0; c < CHANNELS; c++) ema_state[c] = '0;
    end else if (idx == CFG_IDX_CAL) begin
      cal_on = val[0];
    end
  endtask

  task automatic send_calibration_run();
    offer_request(make_req(ACT_TRACK_START, $urandom_range(0, 3), pick_raw()), 1'b0, '0);
    for (int c = 0; c < CHANNELS; c++)
      if ($urandom_range(0, 4) != 0)
        repeat ($urandom_range(1, 4))
          offer_request(make_req(ACT_TRACK_SAMPLE, c, pick_raw()), 1'b0, '0);
    if ($urandom_range(0, 9) != 0)
      offer_request(make_req(ACT_COMMIT, $urandom_range(0, 3), pick_raw()), 1'b0, '0);
  endtask

  task automatic send_random_traffic(input int unsigned count);
    int unsigned target;
    int unsigned roll;
    target = requests_sent + count;
    while (requests_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 8)
        send_calibration_run();
      else if (roll < 14)
        offer_request(make_req(action_t'($urandom_range(0, 3)), $urandom_range(0, 3),
                               pick_raw()), 1'b0, '0);
      else
        offer_request(make_req(ACT_SAMPLE, $urandom_range(0, 3), pick_raw()), 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int unsigned snd, input int unsigned rcv,
                           input logic flt, input logic cal, input bit squeeze,
                           input int unsigned count);
    write_reg(CFG_IDX_FILTER, flt);
    write_reg(CFG_IDX_CAL, cal);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    if (squeeze) hold_req_cnt++;
    send_random_traffic(count);
  endtask

  always @(posedge clk) begin
    out_res_t want;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_failure($sformatf("unexpected result ch %0d raw %0d level %0d",
                               out_data.out_channel, out_data.out_raw, out_data.level));
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_channel !== want.out_channel)
          flag_failure($sformatf("out_channel exp %0d got %0d",
                                 want.out_channel, out_data.out_channel));
        if (out_data.out_raw !== want.out_raw)
          flag_failure($sformatf("out_raw exp %0d got %0d", want.out_raw, out_data.out_raw));
        if (out_data.level !== want.level)
          flag_failure($sformatf("level ch %0d raw %0d exp %0d got %0d", want.out_channel,
                                 want.out_raw, want.level, out_data.level));
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("tb_sensor_calibrate_normalize_ema_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    row_t row;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    requests_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req_cnt  = 0;
    model_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // uncalibrated full-scale path, filter bypassed
    plan.push_back(reg_row(CFG_IDX_FILTER, 1'b0));
    plan.push_back(chk_row(0, 0, '0));
    plan.push_back(chk_row(1, 4095, LEVEL_ONE));
    plan.push_back(req_row(ACT_SAMPLE, 2, 2048));
    // commit with nothing tracked gives an empty range
    plan.push_back(req_row(ACT_COMMIT, 1, 77));
    plan.push_back(chk_row(3, 100, LEVEL_HALF));
    plan.push_back(req_row(ACT_TRACK_START, 2, 4095));
    plan.push_back(req_row(ACT_TRACK_SAMPLE, 0, 1000));
    plan.push_back(req_row(ACT_TRACK_SAMPLE, 0, 3000));
    plan.push_back(req_row(ACT_TRACK_SAMPLE, 1, 4095));
    plan.push_back(req_row(ACT_TRACK_SAMPLE, 1, 0));
    plan.push_back(req_row(ACT_TRACK_SAMPLE, 2, 2000));
    plan.push_back(req_row(ACT_COMMIT, 3, 4095));
    plan.push_back(chk_row(0, 1000, '0));
    plan.push_back(chk_row(0, 3000, LEVEL_ONE));
    plan.push_back(req_row(ACT_SAMPLE, 0, 2000));
    plan.push_back(chk_row(0, 0, '0));
    plan.push_back(chk_row(2, 2000, LEVEL_HALF));
    plan.push_back(chk_row(3, 5, LEVEL_HALF));
    plan.push_back(chk_row(1, 4095, LEVEL_ONE));
    plan.push_back(req_row(ACT_SAMPLE, 1, 1));
    plan.push_back(reg_row(CFG_IDX_CAL, 1'b0));
    plan.push_back(chk_row(0, 4095, LEVEL_ONE));
    plan.push_back(reg_row(CFG_IDX_FILTER, 1'b1));
    plan.push_back(reg_row(CFG_IDX_CAL, 1'b1));
    plan.push_back(reg_row(CFG_IDX_RSVD2, 1'b1));
    plan.push_back(reg_row(CFG_IDX_RSVD3, 1'b0));
    plan.push_back(req_row(ACT_SAMPLE, 0, 4095));
    plan.push_back(req_row(ACT_SAMPLE, 0, 4095));
    plan.push_back(req_row(ACT_SAMPLE, 1, 0));
    plan.push_back(req_row(ACT_TRACK_START, 3, 0));
    plan.push_back(req_row(ACT_SAMPLE, 2, 1234));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG)
        write_reg(row.reg_idx, row.reg_val);
      else
        offer_request(row.req, row.typed, row.level);
    end

    run_phase(34, 83, 1'b1, 1'b1, 1'b0, 90);
    run_phase(34, 83, 1'b0, 1'b0, 1'b0, 90);
    run_phase(83, 34, 1'b1, 1'b0, 1'b0, 90);
    run_phase(83, 34, 1'b0, 1'b1, 1'b0, 90);
    run_phase(0, 0, 1'b1, 1'b1, 1'b1, 90);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_sensor_calibrate_normalize_ema_core: done, clean");
    else
      $display("tb_sensor_calibrate_normalize_ema_core: done, errors");
    $finish;
  end

endmodule
